### design/poa_pkg.sv
// Shared types and constants for the proximity obstacle avoidance block.
// Used by poa_div and proximity_obstacle_avoidance; no dependencies.
package poa_pkg;

  localparam int unsigned NUM_SENSORS = 8;
  localparam int unsigned IN_W        = 16;  // raw sample field width
  localparam int unsigned V_W         = 17;  // normalised value, 0 .. 1.0 in units of 2^-16
  localparam int unsigned SUM_W       = 21;  // weighted sum in quarters
  localparam int unsigned FAC_W       = 19;  // factor, signed Q2.16
  localparam int unsigned GAIN_W      = 32;
  localparam int unsigned PROD_W      = FAC_W + GAIN_W;
  localparam int unsigned RND_W       = PROD_W + 1;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned ACC_W       = RND_W - FRAC_BITS + 1;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int          ROUND_BIAS  = 32768;

  // Colour thresholds 0.55, 0.15 and 0.04 in Q0.16
  localparam logic [V_W-1:0] TH_RED    = 17'd36044;
  localparam logic [V_W-1:0] TH_ORANGE = 17'd9830;
  localparam logic [V_W-1:0] TH_YELLOW = 17'd2621;

  typedef logic signed [3:0] weight_t;

  // Weights in quarters, sensors nnw .. nne
  localparam weight_t WEIGHT_TR [NUM_SENSORS] = '{
    -4'sd3, -4'sd3, 4'sd1, 4'sd0, 4'sd0, 4'sd1, -4'sd3, -4'sd3
  };
  localparam weight_t WEIGHT_ROT [NUM_SENSORS] = '{
    -4'sd4, -4'sd2, -4'sd1, 4'sd0, 4'sd0, 4'sd1, 4'sd2, 4'sd4
  };

  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [FAC_W-1:0]  fac_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [1:0] {
    LVL_GREEN  = 2'd0,
    LVL_YELLOW = 2'd1,
    LVL_ORANGE = 2'd2,
    LVL_RED    = 2'd3
  } level_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_PROX_LOW  = 3'd1,
    REG_PROX_HIGH = 3'd2,
    REG_BASE_TR   = 3'd3,
    REG_GAIN_TR   = 3'd4,
    REG_BASE_ROT  = 3'd5,
    REG_GAIN_ROT  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [IN_W-1:0] prox_nnw;
    logic [IN_W-1:0] prox_wnw;
    logic [IN_W-1:0] prox_wsw;
    logic [IN_W-1:0] prox_ssw;
    logic [IN_W-1:0] prox_sse;
    logic [IN_W-1:0] prox_ese;
    logic [IN_W-1:0] prox_ene;
    logic [IN_W-1:0] prox_nne;
  } in_t;

  typedef struct packed {
    logic signed [31:0] translation;
    logic signed [31:0] rotation;
    logic [1:0]         level_nnw;
    logic [1:0]         level_wnw;
    logic [1:0]         level_wsw;
    logic [1:0]         level_ssw;
    logic [1:0]         level_sse;
    logic [1:0]         level_ese;
    logic [1:0]         level_ene;
    logic [1:0]         level_nne;
  } out_t;

endpackage

### design/poa_div.sv
// Pipelined restoring divider, eight lanes sharing one divisor.
// Gives floor(num * 2^16 / den) for num <= den, one quotient bit per stage.
// Depends on poa_pkg.
module poa_div #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [SAMPLE_BITS-1:0]      num_i [poa_pkg::NUM_SENSORS],
  input  logic [SAMPLE_BITS-1:0]      den_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [poa_pkg::V_W-1:0]     quo_o [poa_pkg::NUM_SENSORS]
);
  import poa_pkg::*;

  localparam int unsigned NSTG = V_W;

  logic                   valid_q [NSTG];
  logic                   ready   [NSTG+1];
  logic [SAMPLE_BITS-1:0] den_q   [NSTG];
  logic [SAMPLE_BITS-1:0] rem_q   [NSTG][NUM_SENSORS];
  logic [V_W-1:0]         quo_q   [NSTG][NUM_SENSORS];

  assign ready[NSTG] = !stall_i;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic                   in_valid;
    logic [SAMPLE_BITS-1:0] in_den;
    logic [SAMPLE_BITS:0]   trial    [NUM_SENSORS];
    logic [V_W-1:0]         quo_base [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0] rem_d    [NUM_SENSORS];
    logic [V_W-1:0]         quo_d    [NUM_SENSORS];

    if (k == 0) begin : g_first
      // leading bit: only set when the numerator equals the divisor
      always_comb begin
        in_valid = valid_i;
        in_den   = den_i;
        for (int l = 0; l < NUM_SENSORS; l++) begin
          trial[l]    = {1'b0, num_i[l]};
          quo_base[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        in_valid = valid_q[k-1];
        in_den   = den_q[k-1];
        for (int l = 0; l < NUM_SENSORS; l++) begin
          trial[l]    = {rem_q[k-1][l], 1'b0};
          quo_base[l] = quo_q[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < NUM_SENSORS; l++) begin
        if (trial[l] >= {1'b0, in_den}) begin
          rem_d[l] = SAMPLE_BITS'(trial[l] - {1'b0, in_den});
          quo_d[l] = {quo_base[l][V_W-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[l][SAMPLE_BITS-1:0];
          quo_d[l] = {quo_base[l][V_W-2:0], 1'b0};
        end
      end
    end

    assign ready[k] = !valid_q[k] || ready[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_q[k] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[k] && in_valid) begin
        den_q[k] <= in_den;
        for (int l = 0; l < NUM_SENSORS; l++) begin
          rem_q[k][l] <= rem_d[l];
          quo_q[k][l] <= quo_d[l];
        end
      end
    end
  end

  assign stall_o = !ready[0];
  assign valid_o = valid_q[NSTG-1];
  assign quo_o   = quo_q[NSTG-1];

endmodule

### design/proximity_obstacle_avoidance.sv
// Top level of the proximity obstacle avoidance block: configuration
// registers, clamp stage, divider instance and the command stages.
// Depends on poa_pkg and poa_div.
//
// Takes one transfer of eight proximity samples per cycle and returns one
// result transfer per input while enable is set; inputs taken with enable
// clear are dropped. The pipeline is one clamp stage, 17 divider
// stages (poa_div, one quotient bit per stage per sensor), one stage for
// colour grading and the weighted sums, one for the gain multiplies and
// one for rounding, base add and saturation into the output register.
// Stages hold their contents under output stall and empty stages are
// filled, so input transfers continue until the whole pipeline is full.
// Configuration is meant to be written only while the pipeline is empty.
module proximity_obstacle_avoidance #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [poa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [poa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  poa_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output poa_pkg::out_t                   out_data_o
);
  import poa_pkg::*;

  // configuration registers
  logic               enable_q;
  logic [IN_W-1:0]    prox_low_q;
  logic [IN_W-1:0]    prox_high_q;
  logic signed [31:0] base_tr_q;
  logic signed [31:0] gain_tr_q;
  logic signed [31:0] base_rot_q;
  logic signed [31:0] gain_rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      prox_low_q  <= '0;
      prox_high_q <= '1;
      base_tr_q   <= '0;
      gain_tr_q   <= '0;
      base_rot_q  <= '0;
      gain_rot_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE:    enable_q    <= cfg_data_i[0];
        REG_PROX_LOW:  prox_low_q  <= cfg_data_i[IN_W-1:0];
        REG_PROX_HIGH: prox_high_q <= cfg_data_i[IN_W-1:0];
        REG_BASE_TR:   base_tr_q   <= signed'(cfg_data_i);
        REG_GAIN_TR:   gain_tr_q   <= signed'(cfg_data_i);
        REG_BASE_ROT:  base_rot_q  <= signed'(cfg_data_i);
        REG_GAIN_ROT:  gain_rot_q  <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- clamp
  logic [IN_W-1:0]        prox   [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] samp   [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] lo, hi;
  logic                   range_ok;
  logic [SAMPLE_BITS-1:0] num1_d [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] den1_d;
  logic                   v1_q;
  logic [SAMPLE_BITS-1:0] num1_q [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] den1_q;
  logic                   rdy1;

  assign prox[0] = in_data_i.prox_nnw;
  assign prox[1] = in_data_i.prox_wnw;
  assign prox[2] = in_data_i.prox_wsw;
  assign prox[3] = in_data_i.prox_ssw;
  assign prox[4] = in_data_i.prox_sse;
  assign prox[5] = in_data_i.prox_ese;
  assign prox[6] = in_data_i.prox_ene;
  assign prox[7] = in_data_i.prox_nne;

  always_comb begin
    lo       = prox_low_q[SAMPLE_BITS-1:0];
    hi       = prox_high_q[SAMPLE_BITS-1:0];
    range_ok = hi > lo;
    // empty range: zero over one gives a zero value on every lane
    den1_d   = range_ok ? SAMPLE_BITS'(hi - lo) : SAMPLE_BITS'(1);
    for (int l = 0; l < NUM_SENSORS; l++) begin
      samp[l] = prox[l][SAMPLE_BITS-1:0];
      if (!range_ok) begin
        num1_d[l] = '0;
      end else if (samp[l] > hi) begin
        num1_d[l] = SAMPLE_BITS'(hi - lo);
      end else if (samp[l] < lo) begin
        num1_d[l] = '0;
      end else begin
        num1_d[l] = SAMPLE_BITS'(samp[l] - lo);
      end
    end
  end

  logic                div_stall;
  logic                div_valid;
  logic                div_ready;
  logic [V_W-1:0]      quo [NUM_SENSORS];

  assign rdy1       = !v1_q || !div_stall;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i && enable_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      num1_q <= num1_d;
      den1_q <= den1_d;
    end
  end

  // -------------------------------------------------------------- divider
  poa_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .stall_o (div_stall),
    .num_i   (num1_q),
    .den_i   (den1_q),
    .valid_o (div_valid),
    .stall_i (!div_ready),
    .quo_o   (quo)
  );

  // ------------------------------------------------ grading, weighted sums
  logic   v2_q, v3_q, v4_q;
  logic   rdy2, rdy3, rdy4;
  level_e lvl2_d [NUM_SENSORS];
  level_e lvl2_q [NUM_SENSORS];
  level_e lvl3_q [NUM_SENSORS];
  sum_t   sum_tr, sum_rot;
  fac_t   fac_tr_q, fac_rot_q;

  assign rdy4      = !v4_q || !out_stall_i;
  assign rdy3      = !v3_q || rdy4;
  assign rdy2      = !v2_q || rdy3;
  assign div_ready = rdy2;

  always_comb begin
    sum_tr  = '0;
    sum_rot = '0;
    for (int l = 0; l < NUM_SENSORS; l++) begin
      if (quo[l] > TH_RED) begin
        lvl2_d[l] = LVL_RED;
      end else if (quo[l] > TH_ORANGE) begin
        lvl2_d[l] = LVL_ORANGE;
      end else if (quo[l] > TH_YELLOW) begin
        lvl2_d[l] = LVL_YELLOW;
      end else begin
        lvl2_d[l] = LVL_GREEN;
      end
      sum_tr  = sum_tr  + sum_t'(quo[l]) * sum_t'(WEIGHT_TR[l]);
      sum_rot = sum_rot + sum_t'(quo[l]) * sum_t'(WEIGHT_ROT[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= div_valid;
    end
  end

  // weights are in quarters; arithmetic shift floors toward minus infinity
  always_ff @(posedge clk_i) begin
    if (rdy2 && div_valid) begin
      lvl2_q    <= lvl2_d;
      fac_tr_q  <= FAC_W'(sum_tr >>> 2);
      fac_rot_q <= FAC_W'(sum_rot >>> 2);
    end
  end

  // ------------------------------------------------------------ gain mult
  prod_t prod_tr_q, prod_rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      lvl3_q     <= lvl2_q;
      prod_tr_q  <= prod_t'(fac_tr_q) * prod_t'(gain_tr_q);
      prod_rot_q <= prod_t'(fac_rot_q) * prod_t'(gain_rot_q);
    end
  end

  // ------------------------------------------- round, add base, saturate
  rnd_t rnd_tr, rnd_rot;
  acc_t acc_tr, acc_rot;
  out_t out_d;
  out_t out_q;

  function automatic logic signed [31:0] sat32(acc_t a);
    logic signed [31:0] r;
    if (!a[ACC_W-1] && (|a[ACC_W-2:31])) begin
      r = 32'sh7fffffff;
    end else if (a[ACC_W-1] && !(&a[ACC_W-2:31])) begin
      r = 32'sh80000000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  always_comb begin
    // round half up: add one half, then floor
    rnd_tr  = rnd_t'(prod_tr_q) + rnd_t'(ROUND_BIAS);
    rnd_rot = rnd_t'(prod_rot_q) + rnd_t'(ROUND_BIAS);
    acc_tr  = acc_t'(signed'(rnd_tr[RND_W-1:FRAC_BITS])) + acc_t'(base_tr_q);
    acc_rot = acc_t'(signed'(rnd_rot[RND_W-1:FRAC_BITS])) + acc_t'(base_rot_q);
    out_d.translation = sat32(acc_tr);
    out_d.rotation    = sat32(acc_rot);
    out_d.level_nnw   = lvl3_q[0];
    out_d.level_wnw   = lvl3_q[1];
    out_d.level_wsw   = lvl3_q[2];
    out_d.level_ssw   = lvl3_q[3];
    out_d.level_sse   = lvl3_q[4];
    out_d.level_ese   = lvl3_q[5];
    out_d.level_ene   = lvl3_q[6];
    out_d.level_nne   = lvl3_q[7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a transfer taken while disabled must not enter the pipeline
  a_disabled_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !enable_q) |=> !v1_q)
    else $error("item entered pipeline while disabled");

  // input is only held off when the clamp stage is occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q)
    else $error("input stalled with empty clamp stage");

  // normalised value never exceeds one
  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_quo_chk
    a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (div_valid && quo[g][V_W-1]) |-> (quo[g][V_W-2:0] == '0))
      else $error("divider quotient above one");
  end
`endif

endmodule
